// ===== design/uart_ri_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_ri_pkg
// Register offsets, bit positions, interrupt ID codes and reset values
// for the 16550-style UART register file.
// ----------------------------------------------------------------------------
package uart_ri_pkg;

    // register offsets
    localparam logic [2:0] ADDR_DATA = 3'd0;  // RBR/THR, DLL with DLAB
    localparam logic [2:0] ADDR_IER  = 3'd1;  // IER, DLH with DLAB
    localparam logic [2:0] ADDR_IIR  = 3'd2;  // IIR read, FCR write
    localparam logic [2:0] ADDR_LCR  = 3'd3;
    localparam logic [2:0] ADDR_MCR  = 3'd4;
    localparam logic [2:0] ADDR_LSR  = 3'd5;
    localparam logic [2:0] ADDR_MSR  = 3'd6;
    localparam logic [2:0] ADDR_SCR  = 3'd7;

    // access kind
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    // IER bits
    localparam int IER_RX_AVAIL = 0;
    localparam int IER_TX_EMPTY = 1;
    localparam int IER_LINE_ERR = 2;
    localparam int IER_MODEM    = 3;

    // interrupt identification codes (low nibble of IIR)
    localparam logic [3:0] ID_NONE   = 4'h1;
    localparam logic [3:0] ID_LINE   = 4'h6;
    localparam logic [3:0] ID_RXDATA = 4'h4;
    localparam logic [3:0] ID_THRE   = 4'h2;
    localparam logic [3:0] ID_MODEM  = 4'h0;

    // MCR bits
    localparam int MC_DTR  = 0;
    localparam int MC_RTS  = 1;
    localparam int MC_OUT1 = 2;
    localparam int MC_OUT2 = 3;
    localparam int MC_LOOP = 4;

    // MSR delta bits
    localparam int MS_DCTS = 0;
    localparam int MS_DDSR = 1;
    localparam int MS_TERI = 2;
    localparam int MS_DDCD = 3;

    localparam int LC_DLAB = 7;

    // reset values
    localparam logic [7:0] MSR_RESET = 8'hB0;
    localparam logic [4:0] MCR_RESET = 5'h08;
    localparam logic [7:0] DLL_RESET = 8'h0C;

    // payload widths
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 24;

endpackage

// ===== design/uart_register_interface_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_register_interface_top
// 16550-style UART register file (no FIFO mode) behind a stream interface.
// ----------------------------------------------------------------------------
//
//  channel | dir | tdata fields (low bit up)                  | tuser
//  --------+-----+--------------------------------------------+----------
//  s_axis  | in  | reg_addr[2:0], wdata[10:3], zero pad        | req_type
//  m_axis  | out | rdata[7:0], irq_level[8], tx_valid[9],      | -
//          |     | tx_byte[17:10], zero pad                    |
//
//  One beat in gives one beat out. The access is decoded and the register
//  state updated in the accept cycle; the result lands in the output
//  register and shows on m_axis the next cycle. One beat per cycle is
//  sustained: s_axis is ready whenever the output register is empty or
//  is being drained in the same cycle, so the only stall is m_axis
//  back-pressure. Reset (synchronous, active low) restores the register
//  reset values and empties the output register.
//
//  Line status bits THRE/TEMT never clear and BI never sets without a
//  serial side, so only DR and OE are held in flops. IIR upper nibble is
//  always zero, so only the ID nibble is stored.
//
module uart_register_interface_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [uart_ri_pkg::S_TDATA_W-1:0] i_s_axis_tdata,  // reg_addr, wdata
    input  logic        i_s_axis_tuser,                         // req_type
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [uart_ri_pkg::M_TDATA_W-1:0] o_m_axis_tdata   // rdata, irq_level,
                                                                // tx_valid, tx_byte
);

    // register state
    logic [3:0] r_ier,   n_ier;
    logic [3:0] r_ident, n_ident;
    logic [7:0] r_lcr,   n_lcr;
    logic       r_dr,    n_dr;      // LSR data ready
    logic       r_oe,    n_oe;      // LSR overrun
    logic [7:0] r_msr,   n_msr;
    logic [4:0] r_mcr,   n_mcr;
    logic [7:0] r_dll,   n_dll;
    logic [7:0] r_dlh,   n_dlh;
    logic [7:0] r_rbr,   n_rbr;
    logic [7:0] r_scr,   n_scr;
    logic       r_thre,  n_thre;    // THR-empty interrupt pending
    logic       r_irq,   n_irq;

    // output register
    logic       r_out_valid;
    logic [7:0] r_rdata,  n_rdata;
    logic       r_txv,    n_txv;
    logic [7:0] r_txb,    n_txb;

    logic       accept;
    logic       is_write;
    logic [2:0] addr;
    logic [7:0] wval;
    logic       dlab;
    logic       reeval;
    logic [3:0] ier_diff;
    logic [7:0] lsr_view;
    logic [3:0] id;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign is_write = (i_s_axis_tuser == uart_ri_pkg::REQ_WRITE);
    assign addr     = i_s_axis_tdata[2:0];
    assign wval     = i_s_axis_tdata[10:3];
    assign dlab     = r_lcr[uart_ri_pkg::LC_DLAB];
    assign ier_diff = r_ier ^ wval[3:0];
    assign lsr_view = {1'b0, 2'b11, 3'b000, r_oe, r_dr};

    // access decode
    always_comb begin
        n_ier   = r_ier;
        n_lcr   = r_lcr;
        n_dr    = r_dr;
        n_oe    = r_oe;
        n_msr   = r_msr;
        n_mcr   = r_mcr;
        n_dll   = r_dll;
        n_dlh   = r_dlh;
        n_rbr   = r_rbr;
        n_scr   = r_scr;
        n_thre  = r_thre;
        n_rdata = 8'h00;
        n_txv   = 1'b0;
        n_txb   = 8'h00;
        reeval  = 1'b0;

        if (!is_write) begin
            unique case (addr)
                uart_ri_pkg::ADDR_DATA: begin
                    if (dlab) begin
                        n_rdata = r_dll;
                    end else begin
                        n_rdata = r_rbr;
                        n_dr    = 1'b0;
                        reeval  = 1'b1;
                    end
                end
                uart_ri_pkg::ADDR_IER: begin
                    n_rdata = dlab ? r_dlh : {4'h0, r_ier};
                end
                uart_ri_pkg::ADDR_IIR: begin
                    n_rdata = {4'h0, r_ident};
                    if (r_ident == uart_ri_pkg::ID_THRE) begin
                        n_thre = 1'b0;
                        reeval = 1'b1;
                    end
                end
                uart_ri_pkg::ADDR_LCR: n_rdata = r_lcr;
                uart_ri_pkg::ADDR_MCR: n_rdata = {3'b000, r_mcr};
                uart_ri_pkg::ADDR_LSR: begin
                    n_rdata = lsr_view;
                    if (r_oe) begin
                        n_oe   = 1'b0;
                        reeval = 1'b1;
                    end
                end
                uart_ri_pkg::ADDR_MSR: begin
                    n_rdata = r_msr;
                    if (r_msr[3:0] != 4'h0) begin
                        n_msr  = {r_msr[7:4], 4'h0};
                        reeval = 1'b1;
                    end
                end
                uart_ri_pkg::ADDR_SCR: n_rdata = r_scr;
            endcase
        end else begin
            unique case (addr)
                uart_ri_pkg::ADDR_DATA: begin
                    if (dlab) begin
                        n_dll = wval;
                    end else begin
                        if (r_mcr[uart_ri_pkg::MC_LOOP]) begin
                            n_rbr = wval;
                            n_oe  = r_oe || r_dr;
                            n_dr  = 1'b1;
                        end else begin
                            n_txv = 1'b1;
                            n_txb = wval;
                        end
                        n_thre = 1'b1;
                        reeval = 1'b1;
                    end
                end
                uart_ri_pkg::ADDR_IER: begin
                    if (dlab) begin
                        n_dlh = wval;
                    end else begin
                        n_ier = wval[3:0];
                        if (ier_diff != 4'h0) begin
                            // THRE always set here, so pending follows the enable
                            if (ier_diff[uart_ri_pkg::IER_TX_EMPTY])
                                n_thre = wval[uart_ri_pkg::IER_TX_EMPTY];
                            reeval = 1'b1;
                        end
                    end
                end
                uart_ri_pkg::ADDR_IIR: reeval = 1'b1;  // FCR: value ignored
                uart_ri_pkg::ADDR_LCR: n_lcr = wval;
                uart_ri_pkg::ADDR_MCR: begin
                    n_mcr = wval[4:0];
                    n_msr = {4'h0, r_msr[3:0]};
                    if (wval[uart_ri_pkg::MC_LOOP]) begin
                        n_msr[uart_ri_pkg::MS_DCTS] = r_msr[uart_ri_pkg::MS_DCTS]
                                                    | wval[uart_ri_pkg::MC_RTS];
                        n_msr[uart_ri_pkg::MS_DDSR] = r_msr[uart_ri_pkg::MS_DDSR]
                                                    | wval[uart_ri_pkg::MC_DTR];
                        n_msr[uart_ri_pkg::MS_TERI] = r_msr[uart_ri_pkg::MS_TERI]
                                                    | wval[uart_ri_pkg::MC_OUT1];
                        n_msr[uart_ri_pkg::MS_DDCD] = r_msr[uart_ri_pkg::MS_DDCD]
                                                    | wval[uart_ri_pkg::MC_OUT2];
                    end
                end
                uart_ri_pkg::ADDR_LSR: ;  // read only
                uart_ri_pkg::ADDR_MSR: ;  // read only
                uart_ri_pkg::ADDR_SCR: n_scr = wval;
            endcase
        end
    end

    // priority interrupt identification on the updated state
    always_comb begin
        if (n_ier[uart_ri_pkg::IER_LINE_ERR] && n_oe)
            id = uart_ri_pkg::ID_LINE;
        else if (n_ier[uart_ri_pkg::IER_RX_AVAIL] && n_dr)
            id = uart_ri_pkg::ID_RXDATA;
        else if (n_ier[uart_ri_pkg::IER_TX_EMPTY] && n_thre)
            id = uart_ri_pkg::ID_THRE;
        else if (n_ier[uart_ri_pkg::IER_MODEM] && (n_msr[3:0] != 4'h0))
            id = uart_ri_pkg::ID_MODEM;
        else
            id = uart_ri_pkg::ID_NONE;
        n_ident = reeval ? id : r_ident;
        n_irq   = reeval ? (id != uart_ri_pkg::ID_NONE) : r_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ier   <= 4'h0;
            r_ident <= uart_ri_pkg::ID_NONE;
            r_lcr   <= 8'h00;
            r_dr    <= 1'b0;
            r_oe    <= 1'b0;
            r_msr   <= uart_ri_pkg::MSR_RESET;
            r_mcr   <= uart_ri_pkg::MCR_RESET;
            r_dll   <= uart_ri_pkg::DLL_RESET;
            r_dlh   <= 8'h00;
            r_rbr   <= 8'h00;
            r_scr   <= 8'h00;
            r_thre  <= 1'b0;
            r_irq   <= 1'b0;
        end else if (accept) begin
            r_ier   <= n_ier;
            r_ident <= n_ident;
            r_lcr   <= n_lcr;
            r_dr    <= n_dr;
            r_oe    <= n_oe;
            r_msr   <= n_msr;
            r_mcr   <= n_mcr;
            r_dll   <= n_dll;
            r_dlh   <= n_dlh;
            r_rbr   <= n_rbr;
            r_scr   <= n_scr;
            r_thre  <= n_thre;
            r_irq   <= n_irq;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rdata <= n_rdata;
            r_txv   <= n_txv;
            r_txb   <= n_txb;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'h00, r_txb, r_txv, r_irq, r_rdata};

endmodule
